// ===== rtl/adfp_pkg.sv =====
// ----------------------------------------------------------------------------
// adfp_pkg
// Shared types, character codes, phase and status codes for the decimal
// fixed-point parser.
// ----------------------------------------------------------------------------
package adfp_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int OUT_W           = 32;
  localparam int FRAC_W          = 3;
  localparam int STATUS_W        = 2;
  localparam int PHASE_W         = 2;
  localparam int POW_W           = 14;

  localparam logic [FRAC_W-1:0] FRAC_MAX   = 3'd4;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 3'd1;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [PHASE_W-1:0] PH_WS    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_INT   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_FRAC  = 2'd2;
  localparam logic [PHASE_W-1:0] PH_TRAIL = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_data;
  } item_t;

  function automatic logic [POW_W-1:0] pow10(input logic [FRAC_W-1:0] k);
    logic [POW_W-1:0] r;
    case (k)
      3'd0:    r = 14'd1;
      3'd1:    r = 14'd10;
      3'd2:    r = 14'd100;
      3'd3:    r = 14'd1000;
      3'd4:    r = 14'd10000;
      default: r = 14'd1;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/adfp_in_stage.sv =====
// ----------------------------------------------------------------------------
// adfp_in_stage
// Input register: captures one character item per transfer and holds it
// until the parse stage takes it.
// ----------------------------------------------------------------------------
module adfp_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  adfp_pkg::item_t item_i,
  output logic           item_valid_o,
  output adfp_pkg::item_t item_o,
  input  logic           take_i
);
  import adfp_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  accept;

  assign in_stall_o   = valid_q && !take_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== rtl/adfp_core.sv =====
// ----------------------------------------------------------------------------
// adfp_core
// Parse stage: phase machine, accumulator and fraction count, zero padding
// by a power of ten, and the result register.
// ----------------------------------------------------------------------------
module adfp_core #(
  parameter int VALUE_WIDTH = adfp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [adfp_pkg::FRAC_W-1:0]     cfg_frac_digits_i,
  input  logic                            item_valid_i,
  input  adfp_pkg::item_t                 item_i,
  output logic                            take_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [adfp_pkg::OUT_W-1:0]      number_value_o,
  output logic [adfp_pkg::STATUS_W-1:0]   parse_status_o
);
  import adfp_pkg::*;

  localparam logic [OUT_W-1:0] OutMask = OUT_W'((65'(1) << VALUE_WIDTH) - 65'(1));

  logic [FRAC_W-1:0]      frac_q;
  logic [PHASE_W-1:0]     phase_q, phase_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [FRAC_W-1:0]      cnt_q, cnt_d;
  logic                   out_valid_q;
  logic [OUT_W-1:0]       value_q;
  logic [STATUS_W-1:0]    status_q;

  logic [FRAC_W-1:0]      fd;
  logic                   fixed;
  logic                   eod;
  logic [7:0]             ch;
  logic                   is_digit, is_ws, is_space, is_prefix, is_dot;
  logic [VALUE_WIDTH-1:0] acc_add;
  logic                   emit, final_val;
  logic [STATUS_W-1:0]    status;
  logic [FRAC_W-1:0]      pad_k;
  logic [OUT_W-1:0]       acc_low, prod, value;

  assign fd        = (frac_q > FRAC_MAX) ? FRAC_MAX : frac_q;
  assign fixed     = (fd != '0);
  assign eod       = item_i.end_of_data;
  assign ch        = item_i.ch;
  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_space  = (ch == CH_SPACE);
  assign is_ws     = is_space || ((ch >= CH_TAB) && (ch <= CH_CR));
  assign is_prefix = (ch == CH_LT) || (ch == CH_GT);
  assign is_dot    = (ch == CH_DOT);
  assign acc_add   = (acc_q << 3) + (acc_q << 1) + VALUE_WIDTH'(ch - CH_ZERO);

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    emit      = 1'b0;
    final_val = 1'b0;
    status    = ST_OK;
    unique case (phase_q)
      PH_WS: begin
        if (eod) begin
          emit   = 1'b1;
          status = ST_SHORT;
        end else if (is_ws) begin
          phase_d = PH_WS;
        end else if (is_digit) begin
          acc_d   = VALUE_WIDTH'(ch - CH_ZERO);
          phase_d = PH_INT;
        end else if (fixed && is_prefix) begin
          phase_d = PH_INT;
        end else if (fixed && is_dot) begin
          cnt_d   = '0;
          phase_d = PH_FRAC;
        end else begin
          emit   = 1'b1;
          status = ST_BAD;
        end
      end
      PH_INT: begin
        if (eod) begin
          emit      = 1'b1;
          final_val = !fixed;
          status    = fixed ? ST_SHORT : ST_OK;
        end else if (is_digit) begin
          acc_d = acc_add;
        end else if (fixed && is_dot) begin
          cnt_d   = '0;
          phase_d = PH_FRAC;
        end else if (is_space) begin
          phase_d = PH_TRAIL;
        end else begin
          emit      = 1'b1;
          final_val = 1'b1;
        end
      end
      PH_FRAC: begin
        if (eod) begin
          emit      = 1'b1;
          final_val = 1'b1;
        end else if (is_digit && (cnt_q < fd)) begin
          acc_d = acc_add;
          cnt_d = cnt_q + 3'd1;
        end else if (is_space) begin
          phase_d = PH_TRAIL;
        end else begin
          emit      = 1'b1;
          final_val = 1'b1;
        end
      end
      default: begin
        if (eod || !is_space) begin
          emit      = 1'b1;
          final_val = 1'b1;
        end
      end
    endcase
  end

  assign pad_k   = (fd > cnt_q) ? (fd - cnt_q) : '0;
  assign acc_low = OUT_W'(64'(acc_q));
  assign prod    = OUT_W'(acc_low * OUT_W'(pow10(pad_k)));
  assign value   = final_val ? (prod & OutMask) : '0;

  assign take_o = item_valid_i && (!emit || !out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= FRAC_RESET;
    end else if (cfg_valid_i) begin
      frac_q <= cfg_frac_digits_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WS;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else if (take_o) begin
      if (emit) begin
        phase_q <= PH_WS;
        acc_q   <= '0;
        cnt_q   <= '0;
      end else begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      value_q  <= value;
      status_q <= status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign number_value_o = value_q;
  assign parse_status_o = status_q;

endmodule

// ===== rtl/ascii_decimal_fixed_parser.sv =====
// An input transfer is registered in the input stage, and its result then in the output register.
// Throughput: one character per cycle while no result is held back by an output stall.
// A result waiting under stall blocks only when a further result is due.
// Reset (rst_ni low, asynchronous): empty pipeline, leading-whitespace phase,
// zero accumulator, frac_digits = 1.
// ----------------------------------------------------------------------------
// ascii_decimal_fixed_parser
// Streams characters into one unsigned decimal number scaled by
// 10^frac_digits (frac_digits clamped to 4), with status and consumed flag per result.
// ----------------------------------------------------------------------------
module ascii_decimal_fixed_parser #(
  parameter int VALUE_WIDTH = adfp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [adfp_pkg::FRAC_W-1:0]   cfg_frac_digits_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    ch_i,
  input  logic                          end_of_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [adfp_pkg::OUT_W-1:0]    number_value_o,
  output logic [adfp_pkg::STATUS_W-1:0] parse_status_o,
  output logic                          char_consumed_o
);
  import adfp_pkg::*;

  item_t in_item;
  item_t s1_item;
  logic  s1_valid;
  logic  take;

  assign in_item.ch          = ch_i;
  assign in_item.end_of_data = end_of_data_i;
  assign cfg_ready_o         = 1'b1;
  assign char_consumed_o     = 1'b0;

  adfp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (in_item),
    .item_valid_o (s1_valid),
    .item_o       (s1_item),
    .take_i       (take)
  );

  adfp_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_frac_digits_i (cfg_frac_digits_i),
    .item_valid_i      (s1_valid),
    .item_i            (s1_item),
    .take_o            (take),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .number_value_o    (number_value_o),
    .parse_status_o    (parse_status_o)
  );

endmodule

// ===== rtl/adfp_checker.sv =====
// ----------------------------------------------------------------------------
// adfp_checker
// Port-level checks on the parser: result codes, error values, consumed
// flag and output hold under stall.
// ----------------------------------------------------------------------------
module adfp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [adfp_pkg::OUT_W-1:0]    number_value_o,
  input logic [adfp_pkg::STATUS_W-1:0] parse_status_o,
  input logic                          char_consumed_o
);
  import adfp_pkg::*;

  a_err_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (parse_status_o != ST_OK) |-> (number_value_o == '0))
    else $error("error result carries a nonzero value");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (parse_status_o == ST_OK) || (parse_status_o == ST_BAD) ||
                    (parse_status_o == ST_SHORT))
    else $error("undefined parse status");

  a_not_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !char_consumed_o)
    else $error("terminating character reported as consumed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(number_value_o) &&
                                   $stable(parse_status_o))
    else $error("stalled result changed");

endmodule

bind ascii_decimal_fixed_parser adfp_checker u_adfp_checker (.*);

// ===== dv/tb_ascii_decimal_fixed_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ascii_decimal_fixed_parser
// Streams characters and end-of-data marks into the parser under random
// idle gaps and output stalls, predicts every result with an in-bench parser,
// and checks each result field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_ascii_decimal_fixed_parser;
  import adfp_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 500;

  typedef struct packed {
    logic [OUT_W-1:0]    value;
    logic [STATUS_W-1:0] status;
    logic                consumed;
  } parse_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [FRAC_W-1:0]   cfg_frac_digits_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          ch_i;
  logic                end_of_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [OUT_W-1:0]    number_value_o;
  logic [STATUS_W-1:0] parse_status_o;
  logic                char_consumed_o;

  // parser model state
  logic [PHASE_W-1:0] num_phase;
  logic [OUT_W-1:0]   num_acc;
  int unsigned        frac_seen;
  logic [FRAC_W-1:0]  frac_cfg;

  parse_result_t pending_results[$];
  int            mismatch_count;
  int            sent_items;
  int            checked_results;
  int            cycle_count;
  int            stall_left;
  bit            quiet;

  ascii_decimal_fixed_parser dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_frac_digits_i(cfg_frac_digits_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .ch_i             (ch_i),
    .end_of_data_i    (end_of_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .number_value_o   (number_value_o),
    .parse_status_o   (parse_status_o),
    .char_consumed_o  (char_consumed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned kept_digits();
    return 32'((frac_cfg > FRAC_MAX) ? FRAC_MAX : frac_cfg);
  endfunction

  function automatic parse_result_t close_number(input logic [STATUS_W-1:0] st);
    parse_result_t r;
    r.value    = '0;
    r.status   = st;
    r.consumed = 1'b0;
    if (st == ST_OK) begin
      r.value = num_acc;
      for (int unsigned n = frac_seen; n < kept_digits(); n++) r.value = r.value * 32'd10;
    end
    num_phase = PH_WS;
    num_acc   = '0;
    frac_seen = 0;
    return r;
  endfunction

  function automatic bit parse_step(input logic [7:0] c, input logic eod,
                                    output parse_result_t r);
    int unsigned fd;
    bit          dig;
    fd  = kept_digits();
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    r   = '0;
    case (num_phase)
      PH_WS: begin
        if (eod) begin
          r = close_number(ST_SHORT);
          return 1'b1;
        end
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return 1'b0;
        if (dig) begin
          num_acc   = OUT_W'(c - CH_ZERO);
          num_phase = PH_INT;
          return 1'b0;
        end
        if (fd != 0 && (c == CH_LT || c == CH_GT)) begin
          num_phase = PH_INT;
          return 1'b0;
        end
        if (fd != 0 && c == CH_DOT) begin
          frac_seen = 0;
          num_phase = PH_FRAC;
          return 1'b0;
        end
        r = close_number(ST_BAD);
        return 1'b1;
      end
      PH_INT: begin
        if (eod) begin
          r = close_number((fd == 0) ? ST_OK : ST_SHORT);
          return 1'b1;
        end
        if (dig) begin
          num_acc = num_acc * 32'd10 + OUT_W'(c - CH_ZERO);
          return 1'b0;
        end
        if (fd != 0 && c == CH_DOT) begin
          frac_seen = 0;
          num_phase = PH_FRAC;
          return 1'b0;
        end
        if (c == CH_SPACE) begin
          num_phase = PH_TRAIL;
          return 1'b0;
        end
        r = close_number(ST_OK);
        return 1'b1;
      end
      PH_FRAC: begin
        if (!eod && dig && frac_seen < fd) begin
          num_acc   = num_acc * 32'd10 + OUT_W'(c - CH_ZERO);
          frac_seen = frac_seen + 1;
          return 1'b0;
        end
        if (!eod && c == CH_SPACE) begin
          num_phase = PH_TRAIL;
          return 1'b0;
        end
        r = close_number(ST_OK);
        return 1'b1;
      end
      default: begin
        if (!eod && c == CH_SPACE) return 1'b0;
        r = close_number(ST_OK);
        return 1'b1;
      end
    endcase
  endfunction

  function automatic int next_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d, t=%0t)",
             what, got, want, checked_results, $realtime);
    mismatch_count++;
  endtask

  task automatic send_char(input logic [7:0] c, input logic eod);
    parse_result_t r;
    int            gap;
    gap = next_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    ch_i          <= c;
    end_of_data_i <= eod;
    do @(posedge clk_i); while (in_stall_o);
    if (parse_step(c, eod, r)) pending_results.push_back(r);
    sent_items++;
  endtask

  task automatic send_end();
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    send_char(junk, 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic settle_pipeline();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_frac(input logic [FRAC_W-1:0] v);
    settle_pipeline();
    @(negedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_frac_digits_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    frac_cfg = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // reset value of one fractional digit: whitespace, prefix, fraction, trailing space
  task automatic test_fixed_defaults();
    send_text(">7.5 x");
    send_text("<x");
    send_text("<");
    send_end();
    send_text("8.25");
  endtask

  task automatic test_integer_rules();
    write_frac(3'd0);
    send_text("\t42");
    send_end();
    send_text(".");
  endtask

  task automatic test_clamped_fraction();
    write_frac(3'd7);
    send_char(8'hFF, 1'b0);
    send_text("3 ");
    send_end();
  endtask

  task automatic test_mid_number_config();
    write_frac(3'd1);
    send_text(".1");
    write_frac(3'd3);
    send_text("5");
    send_end();
  endtask

  task automatic send_random_number();
    logic [7:0] c;
    int         roll;
    int         n;
    bit         broken;
    roll   = $urandom_range(0, 99);
    broken = ($urandom_range(0, 9) == 0);
    if (roll < 8) begin
      c = 8'($urandom_range(0, 255));
      send_char(c, 1'b0);
      return;
    end
    if (roll < 11) begin
      send_end();
      return;
    end
    n = $urandom_range(0, 2);
    repeat (n) begin
      c = ($urandom_range(0, 1) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
      send_char(c, 1'b0);
    end
    if ($urandom_range(0, 3) == 0) send_char(($urandom_range(0, 1) == 0) ? CH_LT : CH_GT, 1'b0);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 3);
    repeat (n) send_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    if (broken) begin
      send_end();
      return;
    end
    if ($urandom_range(0, 1) == 0) begin
      send_char(CH_DOT, 1'b0);
      n = $urandom_range(0, kept_digits() + 1);
      repeat (n) send_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    end
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) send_char(CH_SPACE, 1'b0);
    if ($urandom_range(0, 9) < 3) begin
      send_end();
    end else begin
      c = 8'($urandom_range(0, 255));
      send_char(c, 1'b0);
    end
  endtask

  task automatic test_random_stream();
    logic [FRAC_W-1:0] settings[8];
    int                target;
    settings = '{3'd4, 3'd0, 3'd2, 3'd7, 3'd1, 3'd5, 3'd3, 3'd6};
    foreach (settings[k]) begin
      write_frac(settings[k]);
      target = sent_items + RANDOM_ITEMS / 8;
      while (sent_items < target) begin
        quiet = ($urandom_range(0, 5) == 0);
        send_random_number();
      end
      quiet = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    parse_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, value", number_value_o, '0);
      end else begin
        want = pending_results.pop_front();
        if (number_value_o !== want.value)
          report_mismatch("number_value", number_value_o, want.value);
        if (parse_status_o !== want.status)
          report_mismatch("parse_status", OUT_W'(parse_status_o), OUT_W'(want.status));
        if (char_consumed_o !== want.consumed)
          report_mismatch("char_consumed", OUT_W'(char_consumed_o), OUT_W'(want.consumed));
      end
      checked_results++;
    end
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        out_stall_i <= 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:69]:  out_stall_i <= 1'b0;
          [70:96]: begin
            out_stall_i <= 1'b1;
            stall_left = $urandom_range(0, 2);
          end
          default: begin
            out_stall_i <= 1'b1;
            stall_left = $urandom_range(10, 30);
          end
        endcase
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("ascii_decimal_fixed_parser regression: fail");
    $finish;
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_frac_digits_i = '0;
    in_valid_i        = 1'b0;
    ch_i              = '0;
    end_of_data_i     = 1'b0;
    mismatch_count    = 0;
    sent_items        = 0;
    checked_results   = 0;
    stall_left        = 0;
    quiet             = 1'b0;
    frac_cfg          = FRAC_RESET;
    num_phase         = PH_WS;
    num_acc           = '0;
    frac_seen         = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_fixed_defaults();
    test_integer_rules();
    test_clamped_fraction();
    test_mid_number_config();
    test_random_stream();

    quiet = 1'b1;
    settle_pipeline();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ascii_decimal_fixed_parser regression: pass");
    end else begin
      $display("ascii_decimal_fixed_parser regression: fail");
    end
    $finish;
  end

endmodule
